[design/plcl_pkg.sv]
// Shared types, codes and defaults for the piecewise-linear curve table builder.
`default_nettype none
package plcl_pkg;

  localparam int unsigned DEF_CHANNELS = 3;
  localparam int unsigned DEF_ENTRIES  = 256;
  localparam logic [7:0]  LEVEL_MAX    = 8'd255;

  // Result status codes
  localparam logic [1:0] STS_APPLIED  = 2'd0;
  localparam logic [1:0] STS_NOCHANGE = 2'd1;
  localparam logic [1:0] STS_REFUSED  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    GAP_LEFT  = 2'd0,
    GAP_RIGHT = 2'd1,
    GAP_BOTH  = 2'd2
  } gap_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_DN,
    S_DN_CK,
    S_UP,
    S_UP_CK,
    S_GAP,
    S_DIV,
    S_FILL,
    S_RESP
  } fsm_state_e;

  typedef struct packed {
    logic       take_req;
    logic       clr_step;
    logic       look;
    logic       wr_add;
    logic       wr_del;
    logic       scan_dn_start;
    logic       scan_up_start;
    logic       scan_step_dn;
    logic       scan_step_up;
    logic       scan_rd;
    logic       hit_a;
    logic       hit_b;
    logic       gap_start;
    gap_e       gap;
    logic       div_step;
    logic       fill_step;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_read;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_ok;
    op_e  op;
    logic pos_first;
    logic pos_last;
    logic kpresent;
    logic kmatch;
    logic div_last;
    logic fill_done;
  } sts_t;

endpackage
`default_nettype wire

[design/plcl_ctrl.sv]
// Controller state machine: sequences lookup, knot scans, division and gap rewrite.
`default_nettype none
module plcl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire plcl_pkg::sts_t sts_i,
  output plcl_pkg::cmd_t      cmd_o
);
  import plcl_pkg::*;

  fsm_state_e state_q, state_d;
  gap_e       gap_q, gap_d;
  logic [1:0] status_q, status_d;
  logic       read_q, read_d;
  logic       out_valid_q, out_valid_d;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      gap_q       <= GAP_LEFT;
      status_q    <= STS_NOCHANGE;
      read_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gap_q       <= gap_d;
      status_q    <= status_d;
      read_q      <= read_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    gap_d       = gap_q;
    status_d    = status_q;
    read_d      = read_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.gap   = gap_q;
    cmd_o.res_status = status_q;
    cmd_o.res_read   = read_q;

    // drop the result once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          state_d        = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        read_d   = 1'b0;
        status_d = STS_NOCHANGE;
        state_d  = S_RESP;
        if (sts_i.req_ok) begin
          unique case (sts_i.op)
            OP_READ: begin
              read_d   = 1'b1;
              status_d = STS_APPLIED;
            end
            OP_ADD: begin
              if (!sts_i.kmatch) begin
                cmd_o.wr_add = 1'b1;
                status_d     = STS_APPLIED;
                if (!sts_i.pos_first) begin
                  cmd_o.scan_dn_start = 1'b1;
                  state_d             = S_DN;
                end else begin
                  cmd_o.scan_up_start = 1'b1;
                  state_d             = S_UP;
                end
              end
            end
            OP_DEL: begin
              if (sts_i.pos_first || sts_i.pos_last) begin
                status_d = STS_REFUSED;
              end else if (sts_i.kpresent) begin
                cmd_o.wr_del        = 1'b1;
                cmd_o.scan_dn_start = 1'b1;
                status_d            = STS_APPLIED;
                state_d             = S_DN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DN: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_DN_CK;
      end
      S_DN_CK: begin
        if (sts_i.kpresent) begin
          cmd_o.hit_a = 1'b1;
          if (sts_i.op == OP_ADD && sts_i.pos_last) begin
            gap_d   = GAP_LEFT;
            state_d = S_GAP;
          end else begin
            cmd_o.scan_up_start = 1'b1;
            state_d             = S_UP;
          end
        end else begin
          cmd_o.scan_step_dn = 1'b1;
          state_d            = S_DN;
        end
      end
      S_UP: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_UP_CK;
      end
      S_UP_CK: begin
        if (sts_i.kpresent) begin
          cmd_o.hit_b = 1'b1;
          state_d     = S_GAP;
          if (sts_i.op == OP_DEL) gap_d = GAP_BOTH;
          else if (sts_i.pos_first) gap_d = GAP_RIGHT;
          else gap_d = GAP_LEFT;
        end else begin
          cmd_o.scan_step_up = 1'b1;
          state_d            = S_UP;
        end
      end
      S_GAP: begin
        cmd_o.gap_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FILL;
      end
      S_FILL: begin
        if (sts_i.fill_done) begin
          if (gap_q == GAP_LEFT && sts_i.op == OP_ADD && !sts_i.pos_last) begin
            gap_d   = GAP_RIGHT;
            state_d = S_GAP;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[design/plcl_dp.sv]
// Datapath: knot and table memories, scan pointer, gradient divider and fill stepper.
`default_nettype none
module plcl_dp #(
  parameter int unsigned CHANNELS = plcl_pkg::DEF_CHANNELS,
  parameter int unsigned ENTRIES  = plcl_pkg::DEF_ENTRIES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     op_i,
  input  wire logic [1:0]     channel_i,
  input  wire logic [7:0]     position_i,
  input  wire logic [7:0]     level_i,
  input  wire plcl_pkg::cmd_t cmd_i,
  output plcl_pkg::sts_t      sts_o,
  output logic [7:0]          read_level_o,
  output logic [1:0]          status_o
);
  import plcl_pkg::*;

  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW    = CW + IW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Transaction registers
  op_e           op_q;
  logic [CW-1:0] ch_q;
  logic [IW-1:0] pos_q;
  logic [7:0]    lvl_q;
  logic          ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      op_q  <= op_e'(op_i);
      ch_q  <= CW'(channel_i);
      pos_q <= IW'(position_i);
      lvl_q <= level_i;
      ok_q  <= (32'(channel_i) < 32'(CHANNELS)) && (32'(position_i) < 32'(ENTRIES))
               && (op_e'(op_i) != OP_NONE);
    end
  end

  // Clearing sweep counter
  logic [AW-1:0] clr_q;
  logic [IW-1:0] clr_idx;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
  end
  assign clr_idx = clr_q[IW-1:0];

  // Scan pointer and found neighbours
  logic [IW-1:0] s_q, a_q, b_q;
  logic [7:0]    ya_q, yb_q;
  logic [8:0]    kd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_dn_start) s_q <= pos_q - 1'b1;
    else if (cmd_i.scan_up_start) s_q <= pos_q + 1'b1;
    else if (cmd_i.scan_step_dn) s_q <= s_q - 1'b1;
    else if (cmd_i.scan_step_up) s_q <= s_q + 1'b1;
    if (cmd_i.hit_a) begin
      a_q  <= s_q;
      ya_q <= kd_q[7:0];
    end
    if (cmd_i.hit_b) begin
      b_q  <= s_q;
      yb_q <= kd_q[7:0];
    end
  end

  // Gap setup, divider and fill stepper
  logic [IW-1:0] x2_q, span_q, rem_q, i_q, r_q;
  logic [7:0]    y1_q, dy_q, qd_q, q_q;
  logic          up_q;
  logic [2:0]    cnt_q;
  logic [IW-1:0] gx1, gx2;
  logic [7:0]    gy1, gy2;
  logic [IW:0]   trial, rsum;
  logic          tfit, wrap;
  logic [7:0]    q_n, fill_val;

  always_comb begin
    case (cmd_i.gap)
      GAP_LEFT:  begin gx1 = a_q;   gy1 = ya_q;  gx2 = pos_q; gy2 = lvl_q; end
      GAP_RIGHT: begin gx1 = pos_q; gy1 = lvl_q; gx2 = b_q;   gy2 = yb_q;  end
      default:   begin gx1 = a_q;   gy1 = ya_q;  gx2 = b_q;   gy2 = yb_q;  end
    endcase
  end

  assign trial    = {rem_q, dy_q[7]};
  assign tfit     = trial >= {1'b0, span_q};
  assign rsum     = {1'b0, r_q} + {1'b0, rem_q};
  assign wrap     = rsum >= {1'b0, span_q};
  assign q_n      = q_q + qd_q + {7'd0, wrap};
  assign fill_val = up_q ? (y1_q + q_n) : (y1_q - q_n);

  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_start) begin
      x2_q   <= gx2;
      y1_q   <= gy1;
      span_q <= gx2 - gx1;
      up_q   <= gy2 >= gy1;
      dy_q   <= (gy2 >= gy1) ? (gy2 - gy1) : (gy1 - gy2);
      rem_q  <= '0;
      qd_q   <= '0;
      cnt_q  <= '0;
      i_q    <= gx1 + 1'b1;
      q_q    <= '0;
      r_q    <= '0;
    end else if (cmd_i.div_step) begin
      // one quotient bit of the gradient per cycle
      rem_q <= tfit ? IW'(trial - {1'b0, span_q}) : IW'(trial);
      qd_q  <= {qd_q[6:0], tfit};
      dy_q  <= {dy_q[6:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.fill_step) begin
      q_q <= q_n;
      r_q <= wrap ? IW'(rsum - {1'b0, span_q}) : IW'(rsum);
      i_q <= i_q + 1'b1;
    end
  end

  // Memories
  logic [8:0]    knot_mem [DEPTH];
  logic [7:0]    tbl_mem  [DEPTH];
  logic [7:0]    td_q;
  logic          k_we, t_we;
  logic [AW-1:0] k_wa, t_wa, k_ra;
  logic [8:0]    k_wd;
  logic [7:0]    t_wd;

  always_comb begin
    k_we = 1'b0;
    k_wa = {ch_q, pos_q};
    k_wd = '0;
    t_we = 1'b0;
    t_wa = {ch_q, pos_q};
    t_wd = lvl_q;
    if (cmd_i.clr_step) begin
      k_we = 1'b1;
      k_wa = clr_q;
      k_wd = {(clr_idx == '0) || (clr_idx == LAST_IDX),
              (clr_idx == LAST_IDX) ? LEVEL_MAX : 8'd0};
      t_we = 1'b1;
      t_wa = clr_q;
      t_wd = (32'(clr_idx) > 32'(LEVEL_MAX)) ? LEVEL_MAX : 8'(clr_idx);
    end else if (cmd_i.wr_add) begin
      k_we = 1'b1;
      k_wd = {1'b1, lvl_q};
      t_we = 1'b1;
    end else if (cmd_i.wr_del) begin
      k_we = 1'b1;
    end else if (cmd_i.fill_step) begin
      t_we = 1'b1;
      t_wa = {ch_q, i_q};
      t_wd = fill_val;
    end
  end

  assign k_ra = cmd_i.scan_rd ? {ch_q, s_q} : {ch_q, pos_q};

  always_ff @(posedge clk_i) begin
    if (k_we) knot_mem[k_wa] <= k_wd;
    kd_q <= knot_mem[k_ra];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) tbl_mem[t_wa] <= t_wd;
    if (cmd_i.look) td_q <= tbl_mem[{ch_q, pos_q}];
  end

  // Result payload
  logic [7:0] rl_q;
  logic [1:0] st_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rl_q <= cmd_i.res_read ? td_q : 8'd0;
      st_q <= cmd_i.res_status;
    end
  end
  assign read_level_o = rl_q;
  assign status_o     = st_q;

  // Status towards the controller
  always_comb begin
    sts_o.clr_done  = (clr_q == '1);
    sts_o.req_ok    = ok_q;
    sts_o.op        = op_q;
    sts_o.pos_first = (pos_q == '0);
    sts_o.pos_last  = (pos_q == LAST_IDX);
    sts_o.kpresent  = kd_q[8];
    sts_o.kmatch    = kd_q[8] && (kd_q[7:0] == lvl_q);
    sts_o.div_last  = (cnt_q == 3'd7);
    sts_o.fill_done = (i_q == x2_q);
  end

endmodule
`default_nettype wire

[design/piecewise_linear_curve_lut_builder.sv]
// Top level of the piecewise-linear tone curve table builder.
// Keeps per colour channel a set of curve knots and an ENTRIES-entry table rebuilt by
// truncating linear interpolation on every knot edit. After reset a clearing pass over
// every knot and table address loads the endpoint knots and the identity ramp; no
// transaction is taken meanwhile. A read or a refused or unchanged edit passes through
// the lookup, decision and response states only. An applied edit adds a neighbour scan
// that reads and then checks each table position walked (single read port of the knot
// memory), per rewritten gap a setup, the 8-step gradient division and the closing
// check, and a fill that writes the rewritten entries one at a time (single write port
// of the table memory). One transaction is in work at a time; the next is taken while
// a result waits.
`default_nettype none
module piecewise_linear_curve_lut_builder #(
  parameter int unsigned CHANNELS = plcl_pkg::DEF_CHANNELS,
  parameter int unsigned ENTRIES  = plcl_pkg::DEF_ENTRIES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [1:0] channel_i,
  input  wire logic [7:0] position_i,
  input  wire logic [7:0] level_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_level_o,
  output logic [1:0]      status_o
);
  import plcl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  plcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  plcl_dp #(
    .CHANNELS (CHANNELS),
    .ENTRIES  (ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .position_i   (position_i),
    .level_i      (level_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_level_o (read_level_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire
